[rtl/direct_mapped_cache_read_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the direct-mapped cache read core
// Shared property wrappers, clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_READ_CORE_MACROS_SVH
`define DIRECT_MAPPED_CACHE_READ_CORE_MACROS_SVH

// Same-cycle implication
`define DMC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dmc check failed");

// Next-cycle implication
`define DMC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dmc check failed");

`endif

[rtl/dmc_pkg.sv]
// ---------------------------------------------------------------------------
// dmc_pkg
// Sizes, field widths, codes and helpers of the direct-mapped cache core.
// ---------------------------------------------------------------------------
package dmc_pkg;

    // Geometry
    localparam int LINE_BYTES   = 16;
    localparam int LINES        = 8;
    localparam int MEMORY_BYTES = 4096;

    // Fixed field widths
    localparam int ADDR_W = 12;
    localparam int BYTE_W = 8;
    localparam int TIME_W = 24;
    localparam int MISS_W = 16;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int LINE_W = $clog2(LINES);
    localparam int TAG_W  = ADDR_W - OFF_W - LINE_W;
    localparam int MEM_AW = $clog2(MEMORY_BYTES);
    localparam int LD_AW  = LINE_W + OFF_W;
    localparam int CNT_W  = OFF_W + 1;

    localparam int S_TDATA_W = ((ADDR_W + BYTE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((BYTE_W + TIME_W + MISS_W + 7) / 8) * 8;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [MISS_W-1:0] t_miss;
    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [MEM_AW-1:0] t_mem_addr;
    typedef logic [LD_AW-1:0]  t_ld_addr;

    // Codes
    localparam logic MODE_PRELOAD = 1'b0;
    localparam logic MODE_READ    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HIT_TIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY = 2'd1;

    // Reset values
    localparam t_byte HIT_TIME_RST     = 8'd1;
    localparam t_byte MISS_PENALTY_RST = 8'd20;
    localparam t_time TIME_MAX = '1;
    localparam t_miss MISS_MAX = '1;

    // Saturating add of an 8-bit cost to the time counter
    function automatic t_time sat_add_time(input t_time total, input t_byte amount);
        logic [TIME_W:0] sum;
        sum = {1'b0, total} + {{(TIME_W + 1 - BYTE_W){1'b0}}, amount};
        return (sum >= {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

endpackage

[rtl/dmc_ram.sv]
// ---------------------------------------------------------------------------
// dmc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/direct_mapped_cache_read_core.sv]
// ---------------------------------------------------------------------------
// direct_mapped_cache_read_core
// Direct-mapped read cache in front of a byte-wide backing memory, with
// saturating access-time and miss counters.
// ---------------------------------------------------------------------------
//  Channel   Dir  Signals                         Payload
//  s_axis    in   tvalid/tready/tdata/tuser       tuser=mode, tdata=address,write_byte
//  m_axis    out  tvalid/tready/tdata/tuser       tuser=hit, tdata=data,time,misses
//  cfg       in   i_cfg_valid/o_cfg_ready         i_cfg_index, i_cfg_data
//
//  Preload: backing RAM write on accept, then the result.
//  Read hit: tag check, line RAM read, result.
//  Read miss: tag check, then a line refill that moves one byte a cycle
//  through the backing RAM read port into the line RAM, then the result.
//  Synchronous active-low reset clears valid bits, counters and control state;
//  no clearing pass. A stalled output holds one result while the next item runs.
// ---------------------------------------------------------------------------
`include "direct_mapped_cache_read_core_macros.svh"

module direct_mapped_cache_read_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dmc_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // [11:0] address, [19:12] write_byte
    input  logic                              s_axis_tuser,   // [0] mode
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dmc_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // [7:0] data_byte, [31:8] elapsed_time,
                                                              // [47:32] miss_count
    output logic                              m_axis_tuser,   // [0] hit
    // Register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dmc_pkg::BYTE_W-1:0]        i_cfg_data
);

    import dmc_pkg::*;

    // State codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_HREAD  = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic              r_mode;
    t_addr             r_addr;
    logic              r_hit;
    t_byte             r_data;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_vld;
    logic [OFF_W-1:0]  r_rd_idx;
    logic [LINES-1:0]  r_valid;
    t_tag              r_tag [LINES];
    t_time             r_time;
    t_miss             r_miss;
    t_byte             r_hit_time;
    t_byte             r_miss_pen;
    logic              r_out_valid;
    logic              r_out_hit;
    t_byte             r_out_data;
    t_time             r_out_time;
    t_miss             r_out_miss;

    logic              in_fire;
    logic              in_mode;
    t_addr             in_addr;
    t_byte             in_wbyte;
    logic [OFF_W-1:0]  cur_off;
    logic [LINE_W-1:0] cur_line;
    t_tag              cur_tag;
    logic              lookup_hit;
    logic              fill_issue;
    logic              out_free;
    logic              done_fire;
    t_time             done_time;
    t_byte             mem_rdata;
    t_byte             line_rdata;
    logic              line_we;

    // Input unpacking
    assign in_mode  = s_axis_tuser;
    assign in_addr  = s_axis_tdata[ADDR_W-1:0];
    assign in_wbyte = s_axis_tdata[ADDR_W +: BYTE_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Address split of the item in work
    assign cur_off  = r_addr[OFF_W-1:0];
    assign cur_line = r_addr[OFF_W +: LINE_W];
    assign cur_tag  = r_addr[ADDR_W-1 -: TAG_W];

    assign lookup_hit = r_valid[cur_line] && (r_tag[cur_line] == cur_tag);
    assign fill_issue = (r_state == ST_FILL) && (r_cnt < CNT_W'(LINE_BYTES));
    assign out_free   = !r_out_valid || m_axis_tready;
    assign done_fire  = (r_state == ST_DONE) && out_free;
    assign done_time  = (r_mode == MODE_READ) ? sat_add_time(r_time, r_hit_time) : r_time;
    assign line_we    = (r_state == ST_FILL) && r_rd_vld;

    // Backing memory: preload writes, refill reads
    dmc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEMORY_BYTES)
    ) u_backing (
        .i_clk   (i_clk),
        .i_we    (in_fire && (in_mode == MODE_PRELOAD)),
        .i_waddr (t_mem_addr'(in_addr)),
        .i_wdata (in_wbyte),
        .i_raddr (t_mem_addr'({r_addr[ADDR_W-1:OFF_W], r_cnt[OFF_W-1:0]})),
        .o_rdata (mem_rdata)
    );

    // Line data: refill writes, hit reads
    dmc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINES * LINE_BYTES)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (t_ld_addr'({cur_line, r_rd_idx})),
        .i_wdata (mem_rdata),
        .i_raddr (t_ld_addr'({cur_line, cur_off})),
        .o_rdata (line_rdata)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = (in_mode == MODE_READ) ? ST_LOOKUP : ST_DONE;
                end
            end
            ST_LOOKUP: n_state = lookup_hit ? ST_HREAD : ST_FILL;
            ST_HREAD:  n_state = ST_DONE;
            ST_FILL: begin
                if (!fill_issue && r_rd_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_time      <= '0;
            r_miss      <= '0;
            r_hit_time  <= HIT_TIME_RST;
            r_miss_pen  <= MISS_PENALTY_RST;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;

            // Register writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_HIT_TIME:     r_hit_time <= i_cfg_data;
                    CFG_MISS_PENALTY: r_miss_pen <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_mode <= in_mode;
                        r_addr <= in_addr;
                        r_hit  <= 1'b0;
                        r_data <= '0;
                    end
                end
                ST_LOOKUP: begin
                    r_hit    <= lookup_hit;
                    r_cnt    <= '0;
                    r_rd_vld <= 1'b0;
                    // Miss cost is booked at the start of the refill
                    if (!lookup_hit) begin
                        r_time <= sat_add_time(r_time, r_miss_pen);
                        r_miss <= (r_miss == MISS_MAX) ? r_miss : r_miss + 1'b1;
                    end
                end
                ST_HREAD: begin
                    r_data <= line_rdata;
                end
                ST_FILL: begin
                    if (fill_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_rd_vld <= fill_issue;
                    r_rd_idx <= r_cnt[OFF_W-1:0];
                    // Catch the requested byte as it passes into the line
                    if (r_rd_vld && (r_rd_idx == cur_off)) begin
                        r_data <= mem_rdata;
                    end
                    if (!fill_issue && r_rd_vld) begin
                        r_valid[cur_line] <= 1'b1;
                        r_tag[cur_line]   <= cur_tag;
                    end
                end
                ST_DONE: ;
                default: ;
            endcase

            // Output register
            if (done_fire) begin
                r_out_valid <= 1'b1;
                r_out_hit   <= r_hit;
                r_out_data  <= r_data;
                r_out_time  <= done_time;
                r_out_miss  <= r_miss;
                r_time      <= done_time;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = M_TDATA_W'({r_out_miss, r_out_time, r_out_data});

    // Checks
    `DMC_ASSERT_NXT(a_fill_sets_line, (r_state == ST_FILL) && !fill_issue && r_rd_vld,
                    r_valid[cur_line] && (r_tag[cur_line] == cur_tag))
    `DMC_ASSERT_NXT(a_preload_result, done_fire && (r_mode == MODE_PRELOAD),
                    !m_axis_tuser && (m_axis_tdata[BYTE_W-1:0] == '0))
    `DMC_ASSERT_NXT(a_miss_monotone, 1'b1, r_miss >= $past(r_miss))
    `DMC_ASSERT_IMP(a_fill_count, r_state == ST_FILL, r_cnt <= CNT_W'(LINE_BYTES))

endmodule

[sim/direct_mapped_cache_read_core_test.sv]
// ---------------------------------------------------------------------------
// direct_mapped_cache_read_core_test
// Self-checking bench for the direct-mapped cache read core. A queue-fed
// driver sends preloads and reads in random bursts, a clocked predictor keeps
// its own copy of cache, backing memory and counters, and a monitor compares
// every result transfer field by field under random output stalls. Phases
// change the access costs while idle; one phase ping-pongs two blocks on one
// line at the highest costs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module direct_mapped_cache_read_core_test;

    import dmc_pkg::*;

    // Register indexes past the defined list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_HI = 2'd3;

    localparam int MAX_PRINTED = 40;
    localparam int PING_PONG_READS = 40;

    typedef struct {
        logic  mode;
        t_addr addr;
        t_byte wbyte;
        bit    drain;   // hold this item until every result is back
    } t_access_item;

    typedef struct packed {
        logic  hit;
        t_byte data;
        t_time elapsed;
        t_miss misses;
    } t_cache_result;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data  = '0;

    direct_mapped_cache_read_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [11:0] address, [19:12] write_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] data_byte, [31:8] elapsed_time,
                                         // [47:32] miss_count
        .m_axis_tuser  (m_axis_tuser),   // [0] hit
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("direct_mapped_cache_read_core verification failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Cache and counter prediction
    // -----------------------------------------------------------------------
    logic          tag_present [LINES];
    t_tag          tag_store   [LINES];
    t_byte         line_copy   [LINES*LINE_BYTES];
    t_byte         memory_image[MEMORY_BYTES];
    t_time         time_acc;
    t_miss         miss_acc;
    t_byte         cost_hit;
    t_byte         cost_miss;
    t_cache_result expected_results[$];

    int preloads_seen;
    int hits_seen;
    int misses_seen;

    function automatic t_time add_saturating(input t_time acc, input t_byte amount);
        logic [TIME_W:0] sum;
        sum = {1'b0, acc} + {{(TIME_W + 1 - BYTE_W){1'b0}}, amount};
        return (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic void predict_access(input logic mode, input t_addr addr,
                                           input t_byte wbyte);
        t_cache_result     res;
        t_tag              tg;
        logic [LINE_W-1:0] ln;
        logic [OFF_W-1:0]  off;
        int                base;
        {tg, ln, off} = addr;
        res.hit  = 1'b0;
        res.data = '0;
        if (mode == MODE_PRELOAD) begin
            memory_image[addr] = wbyte;
            preloads_seen++;
        end else begin
            if (tag_present[ln] && tag_store[ln] == tg) begin
                res.hit = 1'b1;
                hits_seen++;
            end else begin
                // refill the whole block one byte at a time
                base = int'(addr) - int'(off);
                for (int i = 0; i < LINE_BYTES; i++)
                    line_copy[int'(ln)*LINE_BYTES + i] = memory_image[base + i];
                tag_store[ln]   = tg;
                tag_present[ln] = 1'b1;
                time_acc = add_saturating(time_acc, cost_miss);
                if (miss_acc != MISS_MAX)
                    miss_acc++;
                misses_seen++;
            end
            time_acc = add_saturating(time_acc, cost_hit);
            res.data = line_copy[int'(ln)*LINE_BYTES + int'(off)];
        end
        res.elapsed = time_acc;
        res.misses  = miss_acc;
        expected_results.push_back(res);
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus generation: tracks which blocks are fully written so that a
    // refill never touches an unwritten byte
    // -----------------------------------------------------------------------
    t_access_item pending_accesses[$];
    bit           byte_written[MEMORY_BYTES];
    bit           block_readable[MEMORY_BYTES/LINE_BYTES];
    int           readable_blocks[$];
    int           items_queued;

    function automatic void queue_access(input logic mode, input int addr,
                                         input int wbyte, input bit drain);
        t_access_item item;
        int           blk;
        bit           full;
        item.mode  = mode;
        item.addr  = t_addr'(addr);
        item.wbyte = t_byte'(wbyte);
        item.drain = drain;
        pending_accesses.push_back(item);
        items_queued++;
        if (mode == MODE_PRELOAD) begin
            byte_written[item.addr] = 1'b1;
            blk = int'(item.addr) / LINE_BYTES;
            if (!block_readable[blk]) begin
                full = 1'b1;
                for (int i = 0; i < LINE_BYTES; i++)
                    if (!byte_written[blk*LINE_BYTES + i])
                        full = 1'b0;
                if (full) begin
                    block_readable[blk] = 1'b1;
                    readable_blocks.push_back(blk);
                end
            end
        end
    endfunction

    function automatic void queue_read(input int blk, input int off, input bit drain);
        queue_access(MODE_READ, blk*LINE_BYTES + off, $urandom_range(0, 255), drain);
    endfunction

    // Whole block in rotated order with random bytes
    function automatic void queue_fill_block(input int blk);
        int start;
        start = $urandom_range(0, LINE_BYTES-1);
        for (int k = 0; k < LINE_BYTES; k++)
            queue_access(MODE_PRELOAD, blk*LINE_BYTES + (start + k) % LINE_BYTES,
                         $urandom_range(0, 255), 1'b0);
    endfunction

    function automatic int pick_readable();
        return readable_blocks[$urandom_range(0, readable_blocks.size()-1)];
    endfunction

    function automatic void queue_mixed_traffic(input int count);
        int stop;
        int sel;
        int blk;
        int n;
        int addr;
        stop = items_queued + count;
        while (items_queued < stop) begin
            sel = $urandom_range(0, 99);
            if (sel < 12 || readable_blocks.size() < 2) begin
                // new block, often on a line already in use to force evictions
                if ($urandom_range(0, 1))
                    blk = $urandom_range(0, MEMORY_BYTES/LINE_BYTES - 1);
                else
                    blk = $urandom_range(0, (1 << TAG_W) - 1) * LINES
                          + pick_readable() % LINES;
                queue_fill_block(blk);
            end else if (sel < 65) begin
                // read burst mostly inside one block
                blk = pick_readable();
                n = $urandom_range(2, 10);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 5) == 0)
                        queue_read(pick_readable(), $urandom_range(0, LINE_BYTES-1), 1'b0);
                    else
                        queue_read(blk, $urandom_range(0, LINE_BYTES-1),
                                   k == 0 && $urandom_range(0, 39) == 0);
                end
            end else if (sel < 75) begin
                // write behind a possibly cached copy, then read it back
                addr = pick_readable()*LINE_BYTES + $urandom_range(0, LINE_BYTES-1);
                queue_access(MODE_PRELOAD, addr, $urandom_range(0, 255), 1'b0);
                queue_access(MODE_READ, addr, $urandom_range(0, 255), 1'b0);
            end else if (sel < 85) begin
                queue_access(MODE_PRELOAD, $urandom_range(0, MEMORY_BYTES-1),
                             $urandom_range(0, 255), 1'b0);
            end else begin
                for (int k = 0; k < 4; k++)
                    queue_read(pick_readable(), $urandom_range(0, LINE_BYTES-1), 1'b0);
            end
        end
    endfunction

    // -----------------------------------------------------------------------
    // Input driver: bursts and gaps; prediction runs on each accepted transfer
    // -----------------------------------------------------------------------
    int gap_left;
    int burst_left;
    int items_accepted;
    bit steady_flow;

    always @(posedge i_clk) begin : input_driver
        t_access_item next_access;
        if (!i_rst_n) begin
            s_axis_tvalid  <= 1'b0;
            gap_left       <= 0;
            burst_left     <= 0;
            items_accepted <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_access(s_axis_tuser, s_axis_tdata[ADDR_W-1:0],
                               s_axis_tdata[ADDR_W +: BYTE_W]);
                items_accepted <= items_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    s_axis_tvalid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end else if (pending_accesses.size() == 0 ||
                             (pending_accesses[0].drain && expected_results.size() != 0)) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_access   = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_access.mode;
                    s_axis_tdata  <= {{(S_TDATA_W - ADDR_W - BYTE_W){1'b0}},
                                      next_access.wbyte, next_access.addr};
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        if (steady_flow || $urandom_range(0, 2) == 0)
                            gap_left <= 0;
                        else
                            gap_left <= $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Output stall pattern, with one long hold-off to back up the input
    // -----------------------------------------------------------------------
    int       hold_left;
    bit       long_hold_done;
    int       rx_style;
    bit [5:0] rx_tick;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready  <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
            rx_style       <= 0;
            rx_tick        <= '0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!long_hold_done && items_accepted >= 200) begin
            m_axis_tready  <= 1'b0;
            long_hold_done <= 1'b1;
            hold_left      <= 400;
        end else if (steady_flow) begin
            m_axis_tready <= 1'b1;
        end else begin
            rx_tick <= rx_tick + 1'b1;
            if (rx_tick == '0)
                rx_style <= $urandom_range(0, 3);
            case (rx_style)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_axis_tready <= (rx_tick[1:0] == 2'b00);
                end
                default: begin
                    m_axis_tready <= ($urandom_range(0, 9) != 0);
                end
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor
    // -----------------------------------------------------------------------
    int error_count;
    int results_checked;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] result %0d: %s", $realtime, results_checked, what);
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_cache_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.hit)
                    report_mismatch($sformatf("hit %0b, expected %0b",
                                              m_axis_tuser, want.hit));
                if (m_axis_tdata[7:0] !== want.data)
                    report_mismatch($sformatf("data_byte %0h, expected %0h",
                                              m_axis_tdata[7:0], want.data));
                if (m_axis_tdata[31:8] !== want.elapsed)
                    report_mismatch($sformatf("elapsed_time %0d, expected %0d",
                                              m_axis_tdata[31:8], want.elapsed));
                if (m_axis_tdata[47:32] !== want.misses)
                    report_mismatch($sformatf("miss_count %0d, expected %0d",
                                              m_axis_tdata[47:32], want.misses));
            end
            results_checked++;
        end
    end

    // -----------------------------------------------------------------------
    // Sequencing
    // -----------------------------------------------------------------------
    int cfg_writes;

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= t_byte'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HIT_TIME)
            cost_hit = t_byte'(value);
        else if (idx == CFG_MISS_PENALTY)
            cost_miss = t_byte'(value);
        cfg_writes++;
    endtask

    // Nothing queued, nothing in flight, then a margin for the longest access
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_accesses.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (LINE_BYTES + 12) @(posedge i_clk);
    endtask

    task automatic run_phase(input int hit_cost, input int miss_cost, input int count);
        wait_idle();
        write_register(CFG_HIT_TIME, hit_cost);
        write_register(CFG_MISS_PENALTY, miss_cost);
        queue_mixed_traffic(count);
    endtask

    initial begin
        // state after reset
        for (int i = 0; i < LINES; i++) begin
            tag_present[i] = 1'b0;
            tag_store[i]   = '0;
        end
        for (int i = 0; i < LINES*LINE_BYTES; i++)
            line_copy[i] = 8'h23;
        for (int i = 0; i < MEMORY_BYTES; i++)
            memory_image[i] = '0;
        time_acc  = '0;
        miss_acc  = '0;
        cost_hit  = HIT_TIME_RST;
        cost_miss = MISS_PENALTY_RST;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // writes past the register list leave the defaults alone
        write_register(CFG_RESERVED_LO, 8'h00);
        write_register(CFG_RESERVED_HI, 8'hFF);

        // block 0 holds 00, 11 .. FF; blocks 15 and 255 share line 7
        for (int i = 0; i < LINE_BYTES; i++)
            queue_access(MODE_PRELOAD, i, i * 8'h11, 1'b0);
        queue_fill_block(15);
        queue_fill_block(255);
        queue_access(MODE_PRELOAD, MEMORY_BYTES-1, 8'hFF, 1'b0);

        queue_read(0, 0, 1'b0);                               // cold miss
        queue_read(0, LINE_BYTES-1, 1'b0);                    // hit
        queue_access(MODE_PRELOAD, 5, 8'hA5, 1'b0);           // behind cached copy
        queue_read(0, 5, 1'b0);                               // stale byte on hit
        queue_read(255, LINE_BYTES-1, 1'b0);                  // top address, miss
        queue_read(255, 0, 1'b0);
        queue_read(15, 0, 1'b0);                              // evicts block 255
        queue_read(255, LINE_BYTES-1, 1'b0);                  // evicts block 15
        queue_read(0, 5, 1'b0);
        queue_access(MODE_PRELOAD, MEMORY_BYTES-1, 8'h00, 1'b0);
        queue_read(255, LINE_BYTES-2, 1'b0);
        queue_read(255, LINE_BYTES-1, 1'b0);
        queue_read(15, 7, 1'b1);                              // after a full drain
        queue_read(0, 5, 1'b0);                               // still the stale cached copy

        queue_mixed_traffic(300);

        run_phase(0, 0, 230);
        run_phase(255, 255, 230);
        run_phase(0, 255, 230);
        run_phase(255, 0, 230);
        run_phase($urandom_range(0, 255), $urandom_range(0, 255), 230);

        // ping-pong between two blocks on one line at the highest costs
        wait_idle();
        write_register(CFG_HIT_TIME, 255);
        write_register(CFG_MISS_PENALTY, 255);
        steady_flow = 1'b1;
        for (int k = 0; k < PING_PONG_READS; k++)
            queue_read((k % 2) ? 15 : 255, $urandom_range(0, LINE_BYTES-1), 1'b0);
        for (int k = 0; k < 8; k++)
            queue_read(15, $urandom_range(0, LINE_BYTES-1), 1'b0);
        wait_idle();
        steady_flow = 1'b0;

        run_phase(HIT_TIME_RST, MISS_PENALTY_RST, 60);
        wait_idle();

        $display("Covered %0d input transfers: %0d preloads, %0d hits, %0d misses;",
                 items_accepted, preloads_seen, hits_seen, misses_seen);
        $display("Checked %0d results after %0d register writes; final time %0d, misses %0d.",
                 results_checked, cfg_writes, time_acc, miss_acc);
        if (error_count == 0)
            $display("direct_mapped_cache_read_core verification clean");
        else
            $display("direct_mapped_cache_read_core verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/dmc_pkg.sv
rtl/dmc_ram.sv
rtl/direct_mapped_cache_read_core.sv
sim/direct_mapped_cache_read_core_test.sv
